// File: sv/mnme_pkg.sv
// Shared types, sizes and count saturation for the max-norm multi-index enumerator.
`default_nettype none

package mnme_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int COMP_WIDTH  = 10;
    localparam int INDEX_WIDTH = 32;
    // Counts saturate at 2^INDEX_WIDTH: anything that large exceeds every index.
    localparam int CNT_WIDTH   = INDEX_WIDTH + 1;
    localparam int PROD_WIDTH  = CNT_WIDTH + COMP_WIDTH + 1;

    typedef logic [COMP_WIDTH-1:0] comp_t;
    typedef logic [CNT_WIDTH-1:0]  cnt_t;

    // Partial counts passed along the cell row.
    typedef struct packed {
        cnt_t p;    // completions of the lower digits
        cnt_t d;    // completions that hold a digit equal to the stratum
    } link_t;

    localparam cnt_t CNT_SAT = {1'b1, {INDEX_WIDTH{1'b0}}};

    function automatic cnt_t sat_cnt(input logic [PROD_WIDTH-1:0] x);
        cnt_t r;
        if (|x[PROD_WIDTH-1:INDEX_WIDTH]) begin
            r = CNT_SAT;
        end else begin
            r = {1'b0, x[INDEX_WIDTH-1:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/max_norm_multi_index_enumerator.sv
// Max-norm multi-index enumerator: maps an enumeration position to its multi-index.
// One request at a time. A request runs a count pass over the cell row to check for
// exhaustion, a binary search for the stratum and a final pass, then a digit step per
// active direction (divider: one quotient bit a cycle), then the output step.
// A waiting result does not block the next request; a new result waits in ST_OUT.
// Reset (aresetn low, synchronous): idle, no result held, active_dims = 4, bounds = 1023.
`default_nettype none

module max_norm_multi_index_enumerator
    import mnme_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [COMP_WIDTH-1:0]  cfg_data,
    // requests: [31:0] target_index
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [INDEX_WIDTH-1:0] s_tdata,
    // results: [9:0] comp_0, [19:10] comp_1, [29:20] comp_2, [39:30] comp_3,
    //          [49:40] stratum, [55:50] zero
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [55:0]                 m_tdata,
    // results: [0] exhausted
    output logic                        m_tuser
);

    localparam int TDATA_W = 56;
    localparam int DIM_W   = $clog2(MAX_DIMS + 1);
    localparam int K_W     = $clog2(MAX_DIMS);
    localparam int CNTR_W  = $clog2(MAX_DIMS + 1);

    // register map
    localparam logic [2:0] REG_ACTIVE_DIMS   = 3'd0;
    localparam logic [2:0] REG_UPPER_BOUND_0 = 3'd1;
    localparam logic [2:0] REG_UPPER_BOUND_1 = 3'd2;
    localparam logic [2:0] REG_UPPER_BOUND_2 = 3'd3;
    localparam logic [2:0] REG_UPPER_BOUND_3 = 3'd4;

    // CHECK: count up to the largest bound (exhaustion test)
    // SEARCH: binary search for the stratum, FINAL: counts at the found stratum
    // DIGIT/DIV: peel off digits from the top direction down
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CHECK  = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_FINAL  = 7'b0001000,
        ST_DIGIT  = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    // ---------------- configuration ----------------
    logic [2:0] active_dims_reg;
    comp_t      ub_reg [MAX_DIMS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_dims_reg <= 3'd4;
            for (int j = 0; j < MAX_DIMS; j++) begin
                ub_reg[j] <= '1;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ACTIVE_DIMS:   active_dims_reg <= cfg_data[2:0];
                REG_UPPER_BOUND_0: ub_reg[0] <= cfg_data;
                REG_UPPER_BOUND_1: ub_reg[1] <= cfg_data;
                REG_UPPER_BOUND_2: ub_reg[2] <= cfg_data;
                REG_UPPER_BOUND_3: ub_reg[3] <= cfg_data;
                default: ;  // writes past the last bound are dropped
            endcase
        end
    end

    // directions in use: zero acts as one, clamp at MAX_DIMS
    logic [DIM_W-1:0] d_use;
    comp_t            top;

    always_comb begin
        if (active_dims_reg == '0) begin
            d_use = DIM_W'(1);
        end else if (DIM_W'(active_dims_reg) > DIM_W'(MAX_DIMS)) begin
            d_use = DIM_W'(MAX_DIMS);
        end else begin
            d_use = DIM_W'(active_dims_reg);
        end
        top = '0;
        for (int j = 0; j < MAX_DIMS; j++) begin
            if (DIM_W'(j) < d_use && ub_reg[j] > top) begin
                top = ub_reg[j];
            end
        end
    end

    // ---------------- control and datapath registers ----------------
    state_t                 state_reg, state_next;
    logic [CNTR_W-1:0]      cnt_reg, cnt_next;
    logic [INDEX_WIDTH-1:0] t_reg, t_next;
    comp_t                  s_reg, s_next;
    comp_t                  lo_reg, lo_next;
    comp_t                  hi_reg, hi_next;
    logic [INDEX_WIDTH-1:0] base_reg, base_next;
    logic [INDEX_WIDTH-1:0] r_reg, r_next;
    logic [K_W-1:0]         k_reg, k_next;
    logic                   hit_reg, hit_next;
    logic                   exh_reg, exh_next;
    comp_t                  comp_reg [MAX_DIMS];
    comp_t                  comp_next [MAX_DIMS];
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;

    // ---------------- cell row ----------------
    // Every cell sees the trial stratum in s_reg; the counts ripple one cell per
    // cycle, one register per cell.
    link_t link_in_w  [MAX_DIMS];
    link_t link_out_w [MAX_DIMS];
    cnt_t  span_w     [MAX_DIMS];

    assign link_in_w[0] = '{p: cnt_t'(1), d: '0};

    for (genvar j = 0; j < MAX_DIMS; j++) begin : g_cell
        if (j > 0) begin : g_link
            assign link_in_w[j] = link_out_w[j-1];
        end
        mnme_cell u_cell (
            .aclk     (aclk),
            .active   (DIM_W'(j) < d_use),
            .stratum  (s_reg),
            .bound    (ub_reg[j]),
            .link_in  (link_in_w[j]),
            .link_out (link_out_w[j]),
            .span     (span_w[j])
        );
    end

    // ---------------- shared divider ----------------
    logic                   div_start;
    cnt_t                   div_divisor;
    logic                   div_done;
    comp_t                  div_quot;
    logic [INDEX_WIDTH-1:0] div_rem;

    mnme_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (r_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // ---------------- next state ----------------
    cnt_t                 cum;
    logic                 run_done;
    logic                 cum_gt;
    comp_t                nlo, nhi;
    logic [COMP_WIDTH:0]  mid_sum;
    cnt_t                 span_k;
    link_t                link_k;

    always_comb begin
        cum      = link_out_w[MAX_DIMS-1].p;
        run_done = (cnt_reg == CNTR_W'(MAX_DIMS));
        cum_gt   = (cum > {1'b0, t_reg});
        nlo      = cum_gt ? lo_reg : s_reg + 1'b1;
        nhi      = cum_gt ? s_reg : hi_reg;
        mid_sum  = {1'b0, nlo} + {1'b0, nhi};
        span_k   = span_w[k_reg];
        link_k   = link_in_w[k_reg];

        state_next    = state_reg;
        cnt_next      = cnt_reg;
        t_next        = t_reg;
        s_next        = s_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        base_next     = base_reg;
        r_next        = r_reg;
        k_next        = k_reg;
        hit_next      = hit_reg;
        exh_next      = exh_reg;
        comp_next     = comp_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        div_start     = 1'b0;
        div_divisor   = link_k.d;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    t_next     = s_tdata;
                    s_next     = top;
                    cnt_next   = '0;
                    exh_next   = 1'b0;
                    for (int j = 0; j < MAX_DIMS; j++) begin
                        comp_next[j] = '0;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (run_done) begin
                    cnt_next = '0;
                    if (!cum_gt) begin
                        // target beyond the whole bounded set
                        exh_next   = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        lo_next   = '0;
                        hi_next   = s_reg;
                        base_next = '0;
                        if (s_reg != '0) begin
                            s_next     = s_reg >> 1;
                            state_next = ST_SEARCH;
                        end else begin
                            state_next = ST_FINAL;
                        end
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SEARCH: begin
                if (run_done) begin
                    cnt_next = '0;
                    lo_next  = nlo;
                    hi_next  = nhi;
                    // count below lo is the count at the last failed trial
                    if (!cum_gt) begin
                        base_next = cum[INDEX_WIDTH-1:0];
                    end
                    if (nlo < nhi) begin
                        s_next = mid_sum[COMP_WIDTH:1];
                    end else begin
                        s_next     = nlo;
                        state_next = ST_FINAL;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINAL: begin
                if (run_done) begin
                    cnt_next   = '0;
                    r_next     = t_reg - base_reg;
                    k_next     = K_W'(d_use - DIM_W'(1));
                    hit_next   = 1'b0;
                    state_next = ST_DIGIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIGIT: begin
                if (hit_reg) begin
                    div_start   = 1'b1;
                    div_divisor = link_k.p;
                    state_next  = ST_DIV;
                end else if ({1'b0, r_reg} < span_k) begin
                    div_start   = 1'b1;
                    div_divisor = link_k.d;
                    state_next  = ST_DIV;
                end else begin
                    // this direction carries the stratum value
                    comp_next[k_reg] = s_reg;
                    r_next           = r_reg - span_k[INDEX_WIDTH-1:0];
                    hit_next         = 1'b1;
                    if (k_reg == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        k_next = k_reg - 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    comp_next[k_reg] = div_quot;
                    r_next           = div_rem;
                    if (k_reg == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        k_next     = k_reg - 1'b1;
                        state_next = ST_DIGIT;
                    end
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next = '0;
                    if (!exh_reg) begin
                        for (int j = 0; j < MAX_DIMS; j++) begin
                            m_tdata_next[j*COMP_WIDTH +: COMP_WIDTH] = comp_reg[j];
                        end
                        m_tdata_next[MAX_DIMS*COMP_WIDTH +: COMP_WIDTH] = s_reg;
                    end
                    m_tuser_next  = exh_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg       <= t_next;
        s_reg       <= s_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        base_reg    <= base_next;
        r_reg       <= r_next;
        k_reg       <= k_next;
        hit_reg     <= hit_next;
        exh_reg     <= exh_next;
        comp_reg    <= comp_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    logic comp_ok;

    always_comb begin
        comp_ok = 1'b1;
        for (int j = 0; j < MAX_DIMS; j++) begin
            if (comp_reg[j] > s_reg) begin
                comp_ok = 1'b0;
            end
        end
    end

    a_exh_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("exhausted result carries nonzero data");

    a_comp_in_stratum: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !exh_reg) |-> comp_ok)
        else $error("component above its stratum");

    a_search_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (lo_reg <= s_reg && s_reg < hi_reg))
        else $error("search trial outside its window");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside a digit step");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while one is in work");

endmodule

`default_nettype wire

// File: sv/mnme_cell.sv
// One direction of the counting row: clips its bound and extends the partial counts.
`default_nettype none

module mnme_cell
    import mnme_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  active,
    input  wire comp_t stratum,
    input  wire comp_t bound,
    input  wire link_t link_in,
    output link_t      link_out,
    output cnt_t       span
);

    comp_t                 m;
    logic                  at_top;
    logic [COMP_WIDTH:0]   mult_p;
    logic [COMP_WIDTH:0]   mult_a;
    logic [PROD_WIDTH-1:0] prod_p;
    logic [PROD_WIDTH-1:0] prod_a;
    logic [PROD_WIDTH-1:0] sum_d;
    cnt_t                  span_c;
    link_t                 link_reg;
    link_t                 link_next;
    cnt_t                  span_reg;

    always_comb begin
        at_top = (bound >= stratum);
        m      = at_top ? stratum : bound;
        mult_p = {1'b0, m} + 1'b1;
        // a digit equal to the stratum is counted apart
        mult_a = at_top ? {1'b0, m} : mult_p;
        prod_p = PROD_WIDTH'(link_in.p) * PROD_WIDTH'(mult_p);
        prod_a = PROD_WIDTH'(link_in.d) * PROD_WIDTH'(mult_a);
        span_c = sat_cnt(prod_a);
        sum_d  = PROD_WIDTH'(span_c) + (at_top ? PROD_WIDTH'(link_in.p) : '0);
        if (active) begin
            link_next.p = sat_cnt(prod_p);
            link_next.d = sat_cnt(sum_d);
        end else begin
            link_next = link_in;
        end
    end

    always_ff @(posedge aclk) begin
        link_reg <= link_next;
        span_reg <= span_c;
    end

    assign link_out = link_reg;
    assign span     = span_reg;

endmodule

`default_nettype wire

// File: sv/mnme_div.sv
// Restoring divider, one quotient bit per cycle, for quotients below 2^COMP_WIDTH.
`default_nettype none

module mnme_div
    import mnme_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [INDEX_WIDTH-1:0] dividend,
    input  wire cnt_t                   divisor,
    output logic                        done,
    output comp_t                       quot,
    output logic [INDEX_WIDTH-1:0]      rem
);

    localparam int SH_WIDTH = CNT_WIDTH + COMP_WIDTH - 1;
    localparam int STEP_W   = $clog2(COMP_WIDTH);

    logic                   busy_reg;
    logic                   done_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [SH_WIDTH-1:0]    sh_reg;
    logic [INDEX_WIDTH-1:0] rem_reg;
    comp_t                  quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg   <= SH_WIDTH'(divisor) << (COMP_WIDTH - 1);
            rem_reg  <= dividend;
            quot_reg <= '0;
            step_reg <= STEP_W'(COMP_WIDTH - 1);
        end else if (busy_reg) begin
            if (SH_WIDTH'(rem_reg) >= sh_reg) begin
                rem_reg            <= rem_reg - sh_reg[INDEX_WIDTH-1:0];
                quot_reg[step_reg] <= 1'b1;
            end
            sh_reg   <= sh_reg >> 1;
            step_reg <= step_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire
